// ----- hw/rtl/nearest_neighbour_image_scaler_assert.svh -----
// Assertion macros shared by the scaler RTL.
`ifndef NEAREST_NEIGHBOUR_IMAGE_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOUR_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NNS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/nns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nns_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_OUT_DIM = 1024;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int SW_W    = 7;                          // source dimension register
  localparam int DW_W    = 11;                         // destination dimension register
  localparam int POS_W   = 10;                         // output column / row
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
  localparam int NUM_W   = POS_W + SW_W;               // dividend width
  localparam int QUO_W   = $clog2(MAX_WIDTH);          // source coordinate width
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_PENDING = 1'b1;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [SW_W-1:0] clip_src(input logic [SW_W-1:0] v,
                                                input logic [SW_W-1:0] maxv);
    logic [SW_W-1:0] r;
    if (v == '0) r = SW_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  function automatic logic [DW_W-1:0] clip_dst(input logic [DW_W-1:0] v,
                                                input logic [DW_W-1:0] maxv);
    logic [DW_W-1:0] r;
    if (v == '0) r = DW_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nearest_neighbour_image_scaler.sv -----
// Nearest-neighbour scaler. Load items (action 0) fill the source frame in
// row-major order, one pixel per item; busy stays low. A fetch item (action 1)
// made before the frame is complete is answered with status 1 in the next
// cycle. A fetch of a real pixel holds busy high while the sequencer runs:
// the shared 6-step restoring divider runs once for the source column and
// once for the source row, then the frame store is read and the result is
// registered. Each result is shown for exactly one cycle with strobe high and
// cannot be held off; a new start is taken in that same cycle. After the last
// pixel of the output frame (last = 1) the block returns to loading.
// Configuration writes are taken at any time but belong only to idle periods.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbour_image_scaler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  input  logic [7:0]                 alpha,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nns_pkg::IDX_W-1:0]  cfg_index,
  input  logic [nns_pkg::DW_W-1:0]   cfg_data,
  output logic                       strobe,
  output logic                       status,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_alpha,
  output logic                       last
);
  import nns_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVX = 3'd1;
  localparam logic [2:0] ST_DIVY = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]         state;
  logic [SW_W-1:0]    src_width, src_height;
  logic [DW_W-1:0]    dst_width, dst_height;
  logic [COUNT_W-1:0] load_count;
  logic [POS_W-1:0]   out_col, out_row;
  logic               emitting;
  logic [STEP_W-1:0]  step;
  logic [NUM_W-1:0]   rem;
  logic [DW_W-1:0]    dvs;
  logic [QUO_W-1:0]   quo, sx, sy;
  logic [31:0]        mem [STORE_DEPTH];
  logic [31:0]        rd_data;

  logic [SW_W-1:0]     sw, sh;
  logic [DW_W-1:0]     dw, dh, dw_m1, dh_m1;
  logic [2*SW_W-1:0]   size_full;
  logic [COUNT_W-1:0]  size, load_next;
  logic                complete, load_ok, mem_we, accept;
  logic [POS_W-1:0]    col_c, row_c;
  logic [NUM_W-1:0]    num_x, num_y;
  logic [NUM_W:0]      shifted, diff;
  logic                ge;
  logic [QUO_W-1:0]    quo_next;
  logic [QUO_W+SW_W-1:0] addr_full;
  logic [ADDR_W-1:0]   rd_addr;
  logic [DW_W-1:0]     col_inc;
  logic                fin;

  assign sw = clip_src(src_width, SW_W'(MAX_WIDTH));
  assign sh = clip_src(src_height, SW_W'(MAX_HEIGHT));
  assign dw = clip_dst(dst_width, DW_W'(MAX_OUT_DIM));
  assign dh = clip_dst(dst_height, DW_W'(MAX_OUT_DIM));
  assign dw_m1 = dw - DW_W'(1);
  assign dh_m1 = dh - DW_W'(1);

  assign size_full = {{SW_W{1'b0}}, sw} * {{SW_W{1'b0}}, sh};
  assign size      = size_full[COUNT_W-1:0];
  assign load_next = load_count + COUNT_W'(1);
  assign complete  = (load_count >= size);

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign load_ok   = !emitting && !complete;
  assign mem_we    = accept && (action == ACT_LOAD) && load_ok;

  // Clip the position to the current output size.
  assign col_c = ({1'b0, out_col} < dw) ? out_col : dw_m1[POS_W-1:0];
  assign row_c = ({1'b0, out_row} < dh) ? out_row : dh_m1[POS_W-1:0];
  assign num_x = col_c * sw;
  assign num_y = out_row * sh;

  // Shared restoring divide step: the quotient is known to fit QUO_W bits.
  assign shifted  = {{(NUM_W + 1 - DW_W){1'b0}}, dvs} << step;
  assign diff     = {1'b0, rem} - shifted;
  assign ge       = !diff[NUM_W];
  assign quo_next = {quo[QUO_W-2:0], ge};

  assign addr_full = sy * sw + (QUO_W + SW_W)'(sx);
  assign rd_addr   = addr_full[ADDR_W-1:0];

  assign col_inc = {1'b0, out_col} + DW_W'(1);
  assign fin     = (out_row == dh_m1[POS_W-1:0]) && (out_col == dw_m1[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[load_count[ADDR_W-1:0]] <= {alpha, blue, green, red};
    end
    if (state == ST_READ) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      src_width  <= SW_W'(64);
      src_height <= SW_W'(64);
      dst_width  <= DW_W'(64);
      dst_height <= DW_W'(64);
      load_count <= '0;
      out_col    <= '0;
      out_row    <= '0;
      emitting   <= 1'b0;
      strobe     <= 1'b0;
      step       <= '0;
    end else begin
      // Strobe a pending answer or a finished pixel.
      strobe <= (state == ST_OUT) ||
                (accept && (action == ACT_FETCH) && !emitting && !complete);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_width  <= cfg_data[SW_W-1:0];
          REG_SRC_HEIGHT: src_height <= cfg_data[SW_W-1:0];
          REG_DST_WIDTH:  dst_width  <= cfg_data;
          REG_DST_HEIGHT: dst_height <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == ACT_LOAD) begin
              if (load_ok) begin
                load_count <= load_next;
                if (load_next >= size) emitting <= 1'b1;
              end
            end else if (emitting || complete) begin
              // Start the column divide from the clipped position.
              emitting <= 1'b1;
              out_col  <= col_c;
              out_row  <= row_c;
              rem      <= num_x;
              dvs      <= dw;
              quo      <= '0;
              step     <= STEP_W'(QUO_W - 1);
              state    <= ST_DIVX;
            end else begin
              status    <= STAT_PENDING;
              out_blue  <= '0;
              out_green <= '0;
              out_red   <= '0;
              out_alpha <= '0;
              last      <= 1'b0;
            end
          end
        end
        ST_DIVX, ST_DIVY: begin
          if (step == '0) begin
            quo  <= '0;
            step <= STEP_W'(QUO_W - 1);
            if (state == ST_DIVX) begin
              sx    <= quo_next;
              rem   <= num_y;
              dvs   <= dh;
              state <= ST_DIVY;
            end else begin
              sy    <= quo_next;
              state <= ST_READ;
            end
          end else begin
            if (ge) rem <= diff[NUM_W-1:0];
            quo  <= quo_next;
            step <= step - STEP_W'(1);
          end
        end
        ST_READ: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          status    <= STAT_OK;
          out_blue  <= rd_data[23:16];
          out_green <= rd_data[15:8];
          out_red   <= rd_data[7:0];
          out_alpha <= rd_data[31:24];
          last      <= fin;
          if (fin) begin
            // Drop back to loading a new frame.
            load_count <= '0;
            out_col    <= '0;
            out_row    <= '0;
            emitting   <= 1'b0;
          end else if (col_inc >= dw) begin
            out_col <= '0;
            out_row <= out_row + POS_W'(1);
          end else begin
            out_col <= col_inc[POS_W-1:0];
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "nearest_neighbour_image_scaler_assert.svh"

  `NNS_ASSERT_NEXT(a_fetch_starts, clk, rst, accept && action == ACT_FETCH && emitting, busy, "pixel fetch did not start the sequencer")
  `NNS_ASSERT_NEXT(a_out_strobe, clk, rst, state == ST_OUT, strobe && status == STAT_OK, "no valid pixel after output stage")
  `NNS_ASSERT_IMPL(a_no_strobe_busy, clk, rst, busy, !strobe, "result strobe while busy")
  `NNS_ASSERT_IMPL(a_last_reloads, clk, rst, strobe && last, !emitting, "last pixel did not return to loading")

endmodule

`default_nettype wire
